// ===== sv/weo_pkg.sv =====
`default_nettype none
package weo_pkg;

    localparam int COUNTER_BITS_DEF = 16;
    localparam int CFG_IDX_W        = 8;
    localparam int CORDIC_STEPS     = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_TO_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_BASE     = 8'd1;

    localparam logic [31:0] TICK_TO_LENGTH_RST = 32'd365072;
    localparam logic [31:0] WHEEL_BASE_RST     = 32'd15073;
    localparam logic [31:0] INV_TWO_PI_TURNS   = 32'd683565276;
    localparam logic [33:0] CORDIC_GAIN        = 34'd652032874;
    localparam logic [30:0] SAT_MAG            = 31'h7FFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_MUL_L,
        ST_MUL_R,
        ST_PREP,
        ST_HMUL,
        ST_HDIV,
        ST_CORD_OLD,
        ST_CORD_NEW,
        ST_PICK,
        ST_RMUL,
        ST_RDIV,
        ST_MX,
        ST_MY,
        ST_DONE
    } state_t;

    // arctangent of 2^-i as a binary angle
    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== sv/weo_if.sv =====
`default_nettype none
interface weo_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] left_count;
    logic [15:0] right_count;
    modport source (output valid, left_count, right_count, input ready);
    modport sink   (input valid, left_count, right_count, output ready);
endinterface

interface weo_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] heading_turns;
    modport source (output valid, pos_x, pos_y, heading_turns, input ready);
    modport sink   (input valid, pos_x, pos_y, heading_turns, output ready);
endinterface

interface weo_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [weo_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/wheel_encoder_odometry.sv =====
// Differential-drive wheel odometry in fixed point.
// sample: one pair of raw encoder counts per transfer (left_count, right_count).
// result: one transfer per sample with pos_x, pos_y (signed Q16.16 metres) and
//   heading_turns (binary angle, 2^32 is one turn).
// cfg: register 0 is tick_to_length (Q0.32), register 1 is wheel_base (Q16.16);
//   the port is always ready, write only while no sample is in flight.
// Processing: the first sample after reset goes straight to the done state and
//   then to the output register. Every later sample runs two bit-serial
//   shift-add products for the wheel distances (one multiplier bit per cycle),
//   a 64-step restoring divide for the heading step, two CORDIC passes
//   for the old and new heading, and on a turn another product and 64-step
//   divide for the arc radius, then two more products for the position step.
//   One multiplier, one divider and one CORDIC are shared in sequence; one
//   sample at a time.
// A new sample is taken while the previous result still waits in the output
//   register; if the receiver stalls, the finished update holds in the last
//   state until the output register frees up.
// Reset restores both registers to their defaults, clears heading and
//   position, and arms the first-sample load of the previous counts.
`default_nettype none
module wheel_encoder_odometry #(
    parameter int COUNTER_BITS = weo_pkg::COUNTER_BITS_DEF
) (
    input  wire            clk,
    input  wire            rst_n,
    weo_sample_if.sink     sample,
    weo_result_if.source   result,
    weo_cfg_if.sink        cfg
);
    localparam int CB = COUNTER_BITS;
    localparam int DW = CB + 2;
    localparam logic signed [DW-1:0] THR = DW'((64'd60000 << CB) >> 16);
    localparam logic signed [DW-1:0] MOD = DW'(64'd1 << CB);

    weo_pkg::state_t state_reg, state_next;

    logic [31:0]     ttl_reg, wb_reg;
    logic [CB-1:0]   last_l_reg, last_r_reg;
    logic [31:0]     head_reg, x_reg, y_reg;
    logic            seen_reg;
    logic            out_valid_reg;
    logic [31:0]     out_x_reg, out_y_reg, out_h_reg;

    logic [CB-1:0]   cl_reg, cr_reg;
    logic [CB-1:0]   drm_reg;
    logic            drneg_reg;
    logic signed [31:0] dl_reg, dr_reg;
    logic [31:0]     diffm_reg, summ_reg;
    logic            diffneg_reg, sumneg_reg;
    logic [31:0]     newh_reg;
    logic [63:0]     mc_reg, acc_reg;
    logic [32:0]     mp_reg;
    logic            mneg_reg;
    logic [63:0]     dq_reg;
    logic [33:0]     rem_reg, dv_reg;
    logic [5:0]      cnt_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [31:0] cz_reg;
    logic [1:0]      quad_reg;
    logic signed [33:0] co_reg, so_reg, cn_reg, sn_reg;
    logic [30:0]     rm_reg;
    logic            rneg_reg;

    logic            in_xfer, out_free;
    logic [CB+15:0]  ext_l, ext_r;
    logic signed [DW-1:0] dl_d, dr_d;
    logic [CB-1:0]   dlm, drm;
    logic            mul_done, div_last, cord_last;
    logic [47:0]     dist_m;
    logic [30:0]     dist_sat;
    logic signed [31:0] dist_val;
    logic signed [32:0] diff_w, sum_w;
    logic [31:0]     wb_eff;
    logic [34:0]     trial;
    logic            take;
    logic signed [33:0] sh_x, sh_y, c_c, c_s;
    logic [31:0]     at;
    logic signed [34:0] dsin, dcos;
    logic [33:0]     prod_p;
    logic signed [33:0] prod_v;
    logic [31:0]     step;

    assign in_xfer  = sample.valid && sample.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign sample.ready = (state_reg == weo_pkg::ST_IDLE);
    assign cfg.ready = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.pos_x = out_x_reg;
    assign result.pos_y = out_y_reg;
    assign result.heading_turns = out_h_reg;

    assign ext_l = {{CB{1'b0}}, sample.left_count};
    assign ext_r = {{CB{1'b0}}, sample.right_count};

    always_comb
    begin
        logic signed [DW-1:0] pl, pr, cl, cr, bl, br;
        pl = signed'({2'b00, last_l_reg});
        pr = signed'({2'b00, last_r_reg});
        cl = signed'({2'b00, cl_reg});
        cr = signed'({2'b00, cr_reg});
        bl = pl - cl;
        br = pr - cr;
        dl_d = cl - pl;
        dr_d = cr - pr;
        if (bl > THR)
            dl_d = dl_d + MOD;
        else if (bl < -THR)
            dl_d = dl_d - MOD;
        if (br > THR)
            dr_d = dr_d + MOD;
        else if (br < -THR)
            dr_d = dr_d - MOD;
    end

    assign dlm = dl_d[DW-1] ? CB'(-dl_d) : CB'(dl_d);
    assign drm = dr_d[DW-1] ? CB'(-dr_d) : CB'(dr_d);

    assign mul_done  = (mp_reg == '0);
    assign div_last  = (cnt_reg == 6'd63);
    assign cord_last = (cnt_reg == 6'(weo_pkg::CORDIC_STEPS));

    assign dist_m   = acc_reg[63:16];
    assign dist_sat = (|dist_m[47:31]) ? weo_pkg::SAT_MAG : dist_m[30:0];
    assign dist_val = mneg_reg ? -signed'({1'b0, dist_sat}) : signed'({1'b0, dist_sat});

    assign diff_w = {dr_reg[31], dr_reg} - {dl_reg[31], dl_reg};
    assign sum_w  = {dr_reg[31], dr_reg} + {dl_reg[31], dl_reg};
    assign wb_eff = (wb_reg == '0) ? 32'd1 : wb_reg;

    assign trial = {rem_reg, dq_reg[63]} - {1'b0, dv_reg};
    assign take  = !trial[34];

    assign sh_x = cx_reg >>> cnt_reg[4:0];
    assign sh_y = cy_reg >>> cnt_reg[4:0];
    assign at   = weo_pkg::atan_turns(cnt_reg[4:0]);

    // map the first-quadrant rotation back to the full circle
    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                c_c = cx_reg;
                c_s = cy_reg;
            end
            2'd1:
            begin
                c_c = -cy_reg;
                c_s = cx_reg;
            end
            2'd2:
            begin
                c_c = -cx_reg;
                c_s = -cy_reg;
            end
            default:
            begin
                c_c = cy_reg;
                c_s = -cx_reg;
            end
        endcase
    end

    assign dsin = {sn_reg[33], sn_reg} - {so_reg[33], so_reg};
    assign dcos = {cn_reg[33], cn_reg} - {co_reg[33], co_reg};

    assign prod_p = acc_reg[63:30];
    assign prod_v = mneg_reg ? -signed'(prod_p) : signed'(prod_p);
    assign step   = dq_reg[31:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            weo_pkg::ST_IDLE:
                if (in_xfer)
                    state_next = seen_reg ? weo_pkg::ST_DELTA : weo_pkg::ST_DONE;
            weo_pkg::ST_DELTA:
                state_next = weo_pkg::ST_MUL_L;
            weo_pkg::ST_MUL_L:
                if (mul_done)
                    state_next = weo_pkg::ST_MUL_R;
            weo_pkg::ST_MUL_R:
                if (mul_done)
                    state_next = weo_pkg::ST_PREP;
            weo_pkg::ST_PREP:
                state_next = weo_pkg::ST_HMUL;
            weo_pkg::ST_HMUL:
                if (mul_done)
                    state_next = weo_pkg::ST_HDIV;
            weo_pkg::ST_HDIV:
                if (div_last)
                    state_next = weo_pkg::ST_CORD_OLD;
            weo_pkg::ST_CORD_OLD:
                if (cord_last)
                    state_next = weo_pkg::ST_CORD_NEW;
            weo_pkg::ST_CORD_NEW:
                if (cord_last)
                    state_next = weo_pkg::ST_PICK;
            weo_pkg::ST_PICK:
                state_next = (diffm_reg == '0) ? weo_pkg::ST_MX : weo_pkg::ST_RMUL;
            weo_pkg::ST_RMUL:
                if (mul_done)
                    state_next = weo_pkg::ST_RDIV;
            weo_pkg::ST_RDIV:
                if (div_last)
                    state_next = weo_pkg::ST_MX;
            weo_pkg::ST_MX:
                if (mul_done)
                    state_next = weo_pkg::ST_MY;
            weo_pkg::ST_MY:
                if (mul_done)
                    state_next = weo_pkg::ST_DONE;
            weo_pkg::ST_DONE:
                if (out_free)
                    state_next = weo_pkg::ST_IDLE;
            default:
                state_next = weo_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= weo_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg       <= weo_pkg::TICK_TO_LENGTH_RST;
            wb_reg        <= weo_pkg::WHEEL_BASE_RST;
            last_l_reg    <= '0;
            last_r_reg    <= '0;
            head_reg      <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == weo_pkg::CFG_TICK_TO_LENGTH)
                    ttl_reg <= cfg.data;
                else if (cfg.index == weo_pkg::CFG_WHEEL_BASE)
                    wb_reg <= cfg.data;
            end

            if (state_reg == weo_pkg::ST_IDLE && in_xfer && !seen_reg)
            begin
                last_l_reg <= ext_l[CB-1:0];
                last_r_reg <= ext_r[CB-1:0];
                x_reg      <= '0;
                y_reg      <= '0;
                seen_reg   <= 1'b1;
            end

            if (state_reg == weo_pkg::ST_MX && mul_done)
                x_reg <= x_reg + prod_v[31:0];

            if (state_reg == weo_pkg::ST_MY && mul_done)
            begin
                y_reg      <= y_reg + prod_v[31:0];
                head_reg   <= newh_reg;
                last_l_reg <= cl_reg;
                last_r_reg <= cr_reg;
            end

            if (state_reg == weo_pkg::ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == weo_pkg::ST_DONE && out_free)
        begin
            out_x_reg <= x_reg;
            out_y_reg <= y_reg;
            out_h_reg <= head_reg;
        end

        // shared shift-add multiplier
        if (!mul_done)
        begin
            if (mp_reg[0])
                acc_reg <= acc_reg + mc_reg;
            mc_reg <= {mc_reg[62:0], 1'b0};
            mp_reg <= {1'b0, mp_reg[32:1]};
        end

        case (state_reg)
            weo_pkg::ST_IDLE:
                if (in_xfer)
                begin
                    cl_reg <= ext_l[CB-1:0];
                    cr_reg <= ext_r[CB-1:0];
                end
            weo_pkg::ST_DELTA:
            begin
                drm_reg   <= drm;
                drneg_reg <= dr_d[DW-1];
                mneg_reg  <= dl_d[DW-1];
                acc_reg   <= '0;
                mc_reg    <= {32'd0, ttl_reg};
                mp_reg    <= {{(33 - CB){1'b0}}, dlm};
            end
            weo_pkg::ST_MUL_L:
                if (mul_done)
                begin
                    dl_reg   <= dist_val;
                    mneg_reg <= drneg_reg;
                    acc_reg  <= '0;
                    mc_reg   <= {32'd0, ttl_reg};
                    mp_reg   <= {{(33 - CB){1'b0}}, drm_reg};
                end
            weo_pkg::ST_MUL_R:
                if (mul_done)
                    dr_reg <= dist_val;
            weo_pkg::ST_PREP:
            begin
                diffneg_reg <= diff_w[32];
                diffm_reg   <= diff_w[32] ? 32'(-diff_w) : diff_w[31:0];
                sumneg_reg  <= sum_w[32];
                summ_reg    <= sum_w[32] ? 32'(-sum_w) : sum_w[31:0];
                acc_reg     <= '0;
                mc_reg      <= {32'd0, weo_pkg::INV_TWO_PI_TURNS};
                mp_reg      <= diff_w[32] ? 33'(-diff_w) : {1'b0, diff_w[31:0]};
            end
            weo_pkg::ST_HMUL:
                if (mul_done)
                begin
                    dq_reg  <= acc_reg;
                    rem_reg <= '0;
                    dv_reg  <= {2'b00, wb_eff};
                    cnt_reg <= '0;
                end
            weo_pkg::ST_HDIV, weo_pkg::ST_RDIV:
            begin
                rem_reg <= take ? trial[33:0] : {rem_reg[32:0], dq_reg[63]};
                dq_reg  <= {dq_reg[62:0], take};
                if (div_last && state_reg == weo_pkg::ST_HDIV)
                begin
                    newh_reg <= diffneg_reg ? head_reg - {step[30:0], take}
                                            : head_reg + {step[30:0], take};
                    cnt_reg  <= '0;
                    cx_reg   <= signed'(weo_pkg::CORDIC_GAIN);
                    cy_reg   <= '0;
                    cz_reg   <= signed'({2'b00, head_reg[29:0]});
                    quad_reg <= head_reg[31:30];
                end
                else
                    cnt_reg <= cnt_reg + 6'd1;
            end
            weo_pkg::ST_CORD_OLD, weo_pkg::ST_CORD_NEW:
                if (!cord_last)
                begin
                    if (cz_reg >= 0)
                    begin
                        cx_reg <= cx_reg - sh_y;
                        cy_reg <= cy_reg + sh_x;
                        cz_reg <= cz_reg - signed'(at);
                    end
                    else
                    begin
                        cx_reg <= cx_reg + sh_y;
                        cy_reg <= cy_reg - sh_x;
                        cz_reg <= cz_reg + signed'(at);
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                end
            weo_pkg::ST_PICK:
            begin
                acc_reg <= '0;
                if (diffm_reg == '0)
                begin
                    // straight step along the old heading
                    mc_reg   <= {32'd0, (dr_reg[31] ? 32'(-dr_reg) : dr_reg)};
                    mp_reg   <= co_reg[33] ? 33'(-co_reg) : co_reg[32:0];
                    mneg_reg <= dr_reg[31] ^ co_reg[33];
                end
                else
                begin
                    mc_reg <= {32'd0, wb_eff};
                    mp_reg <= {1'b0, summ_reg};
                end
            end
            weo_pkg::ST_RMUL:
                if (mul_done)
                begin
                    dq_reg  <= acc_reg;
                    rem_reg <= '0;
                    dv_reg  <= {1'b0, diffm_reg, 1'b0};
                    cnt_reg <= '0;
                end
            weo_pkg::ST_MX:
                if (mul_done)
                begin
                    acc_reg <= '0;
                    if (diffm_reg == '0)
                    begin
                        mc_reg   <= {32'd0, (dr_reg[31] ? 32'(-dr_reg) : dr_reg)};
                        mp_reg   <= so_reg[33] ? 33'(-so_reg) : so_reg[32:0];
                        mneg_reg <= dr_reg[31] ^ so_reg[33];
                    end
                    else
                    begin
                        mc_reg   <= {33'd0, rm_reg};
                        mp_reg   <= dcos[34] ? 33'(-dcos) : dcos[32:0];
                        mneg_reg <= !(rneg_reg ^ dcos[34]);
                    end
                end
            default:
            begin
            end
        endcase

        // all iterations in: hold results, start the pass on the new heading
        if (cord_last && state_reg == weo_pkg::ST_CORD_OLD)
        begin
            co_reg   <= c_c;
            so_reg   <= c_s;
            cnt_reg  <= '0;
            cx_reg   <= signed'(weo_pkg::CORDIC_GAIN);
            cy_reg   <= '0;
            cz_reg   <= signed'({2'b00, newh_reg[29:0]});
            quad_reg <= newh_reg[31:30];
        end
        if (cord_last && state_reg == weo_pkg::ST_CORD_NEW)
        begin
            cn_reg <= c_c;
            sn_reg <= c_s;
        end

        // radius done: saturate and start the x product
        if (div_last && state_reg == weo_pkg::ST_RDIV)
        begin
            if (|dq_reg[62:30])
            begin
                rm_reg <= weo_pkg::SAT_MAG;
                mc_reg <= {33'd0, weo_pkg::SAT_MAG};
            end
            else
            begin
                rm_reg <= {dq_reg[29:0], take};
                mc_reg <= {33'd0, dq_reg[29:0], take};
            end
            rneg_reg <= sumneg_reg ^ diffneg_reg;
            acc_reg  <= '0;
            mp_reg   <= dsin[34] ? 33'(-dsin) : dsin[32:0];
            mneg_reg <= sumneg_reg ^ diffneg_reg ^ dsin[34];
        end
    end

endmodule
`default_nettype wire

// ===== tb/sv/tb_weo_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces come from the RTL; this file only gathers shared constants.
package tb_weo_pkg;
    localparam int ODO_LATENCY = 400;
endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam logic [31:0] GAIN = 32'd652032874;
    localparam logic [63:0] TURNS_PER_RAD = 64'd683565276;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic        [31:0] heading;
    } pose_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #5 clk = ~clk;

    weo_sample_if sample_ch();
    weo_result_if result_ch();
    weo_cfg_if    cfg_ch();

    wheel_encoder_odometry DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch.sink),
        .result (result_ch.source),
        .cfg    (cfg_ch.sink)
    );

    int errors = 0;
    longint cycles = 0;
    int send_idle_pct = 6;
    int recv_idle_pct = 59;
    int samples_sent = 0;
    int turns_seen = 0;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    class odometry_scoreboard;
        logic [31:0] tick_len;
        logic [31:0] base;
        logic [15:0] prev_l;
        logic [15:0] prev_r;
        logic [31:0] heading;
        logic [31:0] x_pos;
        logic [31:0] y_pos;
        bit primed;
        pose_t pending[$];
        longint atan_tab[30];

        function new();
            for (int i = 0; i < 30; i++) atan_tab[i] = weo_pkg::atan_turns(i[4:0]);
            tick_len = weo_pkg::TICK_TO_LENGTH_RST;
            base = weo_pkg::WHEEL_BASE_RST;
            prev_l = '0;
            prev_r = '0;
            heading = '0;
            x_pos = '0;
            y_pos = '0;
            primed = 0;
        endfunction

        function void set_reg(logic [weo_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
            if (idx == weo_pkg::CFG_TICK_TO_LENGTH) tick_len = v;
            else if (idx == weo_pkg::CFG_WHEEL_BASE) base = v;
        endfunction

        function longint fshr(longint v, int n);
            return v >>> n;
        endfunction

        function longint mag_mul_shr(longint a, longint b, int n);
            longint unsigned ma, mb, p;
            ma = a < 0 ? -a : a;
            mb = b < 0 ? -b : b;
            p = (ma * mb) >> n;
            return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
        endfunction

        function void cordic(logic [31:0] ang, output longint c, output longint s);
            longint cx, cy, z, tx, ty;
            cx = GAIN;
            cy = 0;
            z = ang[29:0];
            for (int i = 0; i < 30; i++) begin
                tx = fshr(cy, i);
                ty = fshr(cx, i);
                if (z >= 0) begin
                    cx -= tx; cy += ty; z -= atan_tab[i];
                end else begin
                    cx += tx; cy -= ty; z += atan_tab[i];
                end
            end
            case (ang[31:30])
                2'd0: begin c = cx; s = cy; end
                2'd1: begin c = -cy; s = cx; end
                2'd2: begin c = -cx; s = -cy; end
                default: begin c = cy; s = -cx; end
            endcase
        endfunction

        function longint wheel_distance(logic [15:0] cur, logic [15:0] last);
            longint d, back;
            longint unsigned m;
            back = longint'(last) - longint'(cur);
            d = longint'(cur) - longint'(last);
            if (back > 60000) d += 65536;
            else if (back < -60000) d -= 65536;
            m = ((d < 0 ? -d : d) * longint'(tick_len)) >> 16;
            if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
            return d < 0 ? -longint'(m) : longint'(m);
        endfunction

        function void note_sample(logic [15:0] l, logic [15:0] r);
            longint dl, dr, diff, total, co, so, cn, sn, dx, dy, rad;
            longint unsigned b, stepv, q, mdiff, msum;
            logic [31:0] new_h;
            if (!primed) begin
                prev_l = l;
                prev_r = r;
                x_pos = '0;
                y_pos = '0;
                primed = 1;
            end else begin
                dl = wheel_distance(l, prev_l);
                dr = wheel_distance(r, prev_r);
                b = base == 0 ? 1 : base;
                diff = dr - dl;
                total = dr + dl;
                mdiff = diff < 0 ? -diff : diff;
                msum = total < 0 ? -total : total;
                stepv = (mdiff * TURNS_PER_RAD) / b;
                new_h = diff < 0 ? heading - stepv[31:0] : heading + stepv[31:0];
                prev_l = l;
                prev_r = r;
                cordic(heading, co, so);
                cordic(new_h, cn, sn);
                if (diff == 0) begin
                    dx = mag_mul_shr(dr, co, 30);
                    dy = mag_mul_shr(dr, so, 30);
                end else begin
                    turns_seen++;
                    q = (b * msum) / (2 * mdiff);
                    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
                    rad = ((total < 0) != (diff < 0)) ? -longint'(q) : longint'(q);
                    dx = mag_mul_shr(rad, sn - so, 30);
                    dy = -mag_mul_shr(rad, cn - co, 30);
                end
                x_pos = x_pos + dx[31:0];
                y_pos = y_pos + dy[31:0];
                heading = new_h;
            end
            pending.push_back(pose_t'{x_pos, y_pos, heading});
        endfunction

        task check_result(pose_t got);
            pose_t exp_pose;
            if (pending.size() == 0) begin
                report_mismatch("result with no sample outstanding");
                return;
            end
            exp_pose = pending.pop_front();
            if (got.x !== exp_pose.x)
                report_mismatch($sformatf("pos_x %0d, want %0d", got.x, exp_pose.x));
            if (got.y !== exp_pose.y)
                report_mismatch($sformatf("pos_y %0d, want %0d", got.y, exp_pose.y));
            if (got.heading !== exp_pose.heading)
                report_mismatch($sformatf("heading %h, want %h",
                                          got.heading, exp_pose.heading));
        endtask
    endclass

    odometry_scoreboard odo = new();

    initial begin
        sample_ch.valid = 1'b0;
        sample_ch.left_count = '0;
        sample_ch.right_count = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        result_ch.ready = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top failed");
            $finish;
        end
    end

    // accept results at the rising edge, stall the receiver at random
    always @(posedge clk) begin
        if (rst_n && result_ch.valid && result_ch.ready)
            odo.check_result(pose_t'{result_ch.pos_x, result_ch.pos_y,
                                     result_ch.heading_turns});
    end

    always @(negedge clk) begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_sample(input logic [15:0] l, input logic [15:0] r);
        while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        sample_ch.valid <= 1'b1;
        sample_ch.left_count <= l;
        sample_ch.right_count <= r;
        do @(posedge clk); while (!sample_ch.ready);
        odo.note_sample(l, r);
        samples_sent++;
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (odo.pending.size() != 0) @(negedge clk);
        while (guard < tb_weo_pkg::ODO_LATENCY) begin
            @(negedge clk);
            guard++;
        end
    endtask

    task automatic write_reg(input logic [weo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        odo.set_reg(idx, v);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // mostly small motions with random content, some wraps and full-range noise
    task automatic random_run(input int n);
        logic [15:0] l, r;
        int kind;
        l = odo.prev_l;
        r = odo.prev_r;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(99);
            if (kind < 15) begin
                l = 16'($urandom);
                r = 16'($urandom);
            end else if (kind < 30) begin
                l = l + 16'($urandom_range(400)) - 16'd200;
                r = r + 16'($urandom_range(400)) - 16'd200;
                r = ($urandom_range(1)) ? r : l + (r - r);
            end else if (kind < 40) begin
                l = l + 16'd17;
                r = r + 16'd17;
            end else begin
                l = l + 16'($urandom_range(60)) - 16'd30;
                r = r + 16'($urandom_range(60)) - 16'd30;
            end
            send_sample(l, r);
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: first-sample load, zero motion, wraps both ways, extremes
        send_sample(16'hFFFF, 16'h0000);
        send_sample(16'hFFFF, 16'h0000);
        send_sample(16'h0005, 16'hFFF0);
        send_sample(16'hFFFA, 16'h0010);
        send_sample(16'h0064, 16'h0064);
        send_sample(16'h00C8, 16'h00C8);
        send_sample(16'h3000, 16'hA000);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h7000, 16'h9000);
        send_sample(16'h0000, 16'h0000);
        send_sample(16'h5555, 16'hAAAA);
        send_sample(16'hAAAA, 16'h5555);
        drain();

        write_reg(weo_pkg::CFG_TICK_TO_LENGTH, 32'hFFFF_FFFF);
        write_reg(weo_pkg::CFG_WHEEL_BASE, 32'd1);
        send_sample(16'h0000, 16'hEA60);
        send_sample(16'hEA60, 16'h0000);
        send_sample(16'hEA61, 16'h0001);
        send_sample(16'hEA61, 16'h0002);
        drain();
        write_reg(weo_pkg::CFG_WHEEL_BASE, 32'hFFFF_FFFF);
        write_reg(weo_pkg::CFG_TICK_TO_LENGTH, 32'd1);
        send_sample(16'h0100, 16'h0300);
        send_sample(16'h0000, 16'hFFFF);
        drain();
        write_reg(weo_pkg::CFG_WHEEL_BASE, 32'd0);
        write_reg(8'd7, 32'h1234_5678);
        send_sample(16'h0010, 16'h0030);
        drain();

        write_reg(weo_pkg::CFG_TICK_TO_LENGTH, weo_pkg::TICK_TO_LENGTH_RST);
        write_reg(weo_pkg::CFG_WHEEL_BASE, weo_pkg::WHEEL_BASE_RST);
        random_run(600);
        send_idle_pct = 59;
        recv_idle_pct = 6;
        random_run(300);
        // hold off until every result is back
        while (odo.pending.size() != 0) @(negedge clk);
        random_run(300);
        drain();
        write_reg(weo_pkg::CFG_TICK_TO_LENGTH, $urandom);
        write_reg(weo_pkg::CFG_WHEEL_BASE, $urandom_range(32'h0004_0000, 32'h0000_2000));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_run(350);
        drain();
        write_reg(weo_pkg::CFG_TICK_TO_LENGTH, $urandom);
        write_reg(weo_pkg::CFG_WHEEL_BASE, $urandom);
        random_run(350);
        drain();

        $display("covered %0d samples, %0d of them along an arc", samples_sent, turns_seen);
        $display("register sweeps included minimum and maximum settings and wheel base zero");
        if (errors == 0 && odo.pending.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
